@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define CPL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cpl_pkg.sv @@
`timescale 1ns / 1ps

package cpl_pkg;

	localparam int COORD_W     = 32;
	localparam int POS_IN_W    = 8;
	localparam int FIELD_W     = 5;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 80;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LIST   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		OUT_APPEND = 2'd0,
		OUT_REMOVE = 2'd1,
		OUT_LIST   = 2'd2,
		OUT_ERROR  = 2'd3
	} out_kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic      load_in;
		logic      idx_from_pos;
		logic      idx_clr;
		logic      idx_inc;
		logic      rd_en;
		logic      rd_next;
		logic      wr_append;
		logic      wr_shift;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      out_load;
		out_kind_t out_kind;
		logic [1:0] out_status;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       empty;
		logic       pos_bad;
		logic       out_free;
		logic       more;
		logic       at_last;
	} dp_stat_t;

endpackage

@@ rtl/core/cpl_ctrl.sv @@
`timescale 1ns / 1ps

module cpl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cpl_pkg::dp_stat_t  stat,
	output cpl_pkg::ctrl_cmd_t cmd
);
	import cpl_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_DECODE  = 11'b00000000010,
		S_APPEND  = 11'b00000000100,
		S_ERROR   = 11'b00000001000,
		S_RM_RD   = 11'b00000010000,
		S_RM_OUT  = 11'b00000100000,
		S_SH_TEST = 11'b00001000000,
		S_SH_RD   = 11'b00010000000,
		S_SH_WR   = 11'b00100000000,
		S_LS_RD   = 11'b01000000000,
		S_LS_OUT  = 11'b10000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] err_q, err_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		cmd     = '0;
		cmd.out_kind   = OUT_ERROR;
		cmd.out_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_APPEND: begin
						if (stat.full) begin
							err_d   = ST_FULL;
							state_d = S_ERROR;
						end else begin
							state_d = S_APPEND;
						end
					end
					CMD_REMOVE: begin
						if (stat.empty) begin
							err_d   = ST_EMPTY;
							state_d = S_ERROR;
						end else if (stat.pos_bad) begin
							err_d   = ST_RANGE;
							state_d = S_ERROR;
						end else begin
							cmd.idx_from_pos = 1'b1;
							state_d          = S_RM_RD;
						end
					end
					CMD_LIST: begin
						if (stat.empty) begin
							err_d   = ST_EMPTY;
							state_d = S_ERROR;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_LS_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_APPEND: begin
				if (stat.out_free) begin
					cmd.wr_append  = 1'b1;
					cmd.cnt_inc    = 1'b1;
					cmd.out_load   = 1'b1;
					cmd.out_kind   = OUT_APPEND;
					state_d        = S_IDLE;
				end
			end
			S_ERROR: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = OUT_ERROR;
					cmd.out_status = err_q;
					state_d        = S_IDLE;
				end
			end
			S_RM_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RM_OUT;
			end
			S_RM_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_REMOVE;
					state_d      = S_SH_TEST;
				end
			end
			S_SH_TEST: begin
				if (stat.more) begin
					state_d = S_SH_RD;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SH_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_SH_WR;
			end
			S_SH_WR: begin
				// move the entry above down into the gap
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SH_TEST;
			end
			S_LS_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LS_OUT;
			end
			S_LS_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_LIST;
					if (stat.at_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LS_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

endmodule

@@ rtl/core/cpl_dpath.sv @@
`timescale 1ns / 1ps

module cpl_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [cpl_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [1:0]                          s_tuser,
	input  cpl_pkg::ctrl_cmd_t                  cmd,
	output cpl_pkg::dp_stat_t                   stat,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cpl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [1:0]                          m_tuser,
	output logic                                m_tlast
);
	import cpl_pkg::*;

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int MW    = (CW > POS_IN_W) ? CW : POS_IN_W;
	localparam int PAD_W = OUT_TDATA_W - 2 * COORD_W - 2 * FIELD_W;

	// input transaction
	logic [1:0]          cmd_q;
	logic [COORD_W-1:0]  lat_q, lon_q;
	logic [POS_IN_W-1:0] pos_q;

	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] idx_next;

	logic [2*COORD_W-1:0] mem [DEPTH];
	logic [2*COORD_W-1:0] rd_q;
	logic [IW-1:0]        rd_addr, wr_addr;
	logic [2*COORD_W-1:0] wr_data;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [COORD_W-1:0] out_lat_q, out_lon_q;
	logic [FIELD_W-1:0] out_pos_q, out_cnt_q;
	logic               out_last_q;

	logic               out_free;
	logic [COORD_W-1:0] nxt_lat, nxt_lon;
	logic [FIELD_W-1:0] nxt_pos, nxt_cnt;
	logic               nxt_last;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= s_tuser;
			lat_q <= s_tdata[COORD_W-1:0];
			lon_q <= s_tdata[2*COORD_W-1:COORD_W];
			pos_q <= s_tdata[2*COORD_W+POS_IN_W-1:2*COORD_W];
		end
	end

	assign idx_next = CW'(idx_q) + CW'(1);
	assign out_free = !out_valid_q || m_tready;

	assign stat.cmd      = cmd_q;
	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.pos_bad  = (pos_q == '0) || (MW'(pos_q) > MW'(count_q));
	assign stat.out_free = out_free;
	assign stat.more     = (idx_next < count_q);
	assign stat.at_last  = (idx_next == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_from_pos) begin
				idx_q <= IW'(pos_q - POS_IN_W'(1));
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= IW'(idx_next);
			end
		end
	end

	assign rd_addr = cmd.rd_next ? IW'(idx_next) : idx_q;
	assign wr_addr = cmd.wr_append ? IW'(count_q) : idx_q;
	assign wr_data = cmd.wr_append ? {lon_q, lat_q} : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_append || cmd.wr_shift) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		case (cmd.out_kind)
			OUT_APPEND: begin
				nxt_lat  = lat_q;
				nxt_lon  = lon_q;
				nxt_pos  = FIELD_W'(count_q + CW'(1));
				nxt_cnt  = FIELD_W'(count_q + CW'(1));
				nxt_last = 1'b1;
			end
			OUT_REMOVE: begin
				nxt_lat  = rd_q[COORD_W-1:0];
				nxt_lon  = rd_q[2*COORD_W-1:COORD_W];
				nxt_pos  = FIELD_W'(pos_q);
				nxt_cnt  = FIELD_W'(count_q - CW'(1));
				nxt_last = 1'b1;
			end
			OUT_LIST: begin
				nxt_lat  = rd_q[COORD_W-1:0];
				nxt_lon  = rd_q[2*COORD_W-1:COORD_W];
				nxt_pos  = FIELD_W'(idx_next);
				nxt_cnt  = FIELD_W'(count_q);
				nxt_last = (idx_next == count_q);
			end
			default: begin
				nxt_lat  = '0;
				nxt_lon  = '0;
				nxt_pos  = '0;
				nxt_cnt  = FIELD_W'(count_q);
				nxt_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_lat_q    <= nxt_lat;
			out_lon_q    <= nxt_lon;
			out_pos_q    <= nxt_pos;
			out_cnt_q    <= nxt_cnt;
			out_last_q   <= nxt_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_cnt_q, out_pos_q, out_lon_q, out_lat_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/core/compacting_pair_list.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ordered list of up to DEPTH latitude/longitude pairs.
// Slave channel: one transaction per command; tuser is the command
// (append, remove, list), tdata carries the pair and the 1-based position.
// Master channel: result transactions; tuser is the status, tlast marks the
// final result of a command. Append, remove and errors give one result;
// list gives one result per stored pair, in list order.
// Steps from accept to the next accept, with the receiver ready:
//   append or any error: decode, then load the result;
//   list: decode, then a memory read and a result load per stored pair;
//   remove at p: decode, read pair p, load it, then move each later pair down.
// The pair memory, with one read and one write port and a registered read, sets
// this sequence: every entry read and every shift step takes its own memory access.
// Reset empties the list at once; the pair memory needs no clearing.
// A stalled receiver holds the result register and the command waits in
// place; the next command is taken as soon as the current one is done, even
// while its last result still waits in the output register.
module compacting_pair_list #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // latitude[31:0], longitude[63:32], position[71:64]
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // entry_latitude[31:0], entry_longitude[63:32],
	                              // entry_position[68:64], entry_count[73:69], zero
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);
	import cpl_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	cpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cpl_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`CPL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "accepted a second command without decoding the first")
	`CPL_ASSERT(a_no_append_when_full, clk, arst_n, !cmd.cnt_inc || !stat.full, "append committed to a full list")
	`CPL_ASSERT(a_shift_in_range, clk, arst_n, !cmd.wr_shift || stat.more, "shift step past the end of the list")
	`CPL_ASSERT(a_error_is_last, clk, arst_n, !m_tvalid || m_tuser == ST_OK || m_tlast, "error result not marked last")

endmodule

@@ tb/sv/compacting_pair_list_tb.sv @@
`timescale 1ns / 1ps

module compacting_pair_list_tb;

	import cpl_pkg::*;

	localparam int         LIST_DEPTH = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] lat;
		logic [31:0] lon;
	} coord_pair_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] lat;
		logic [31:0] lon;
		logic [4:0]  pos;
		logic [4:0]  cnt;
		logic        is_last;
	} entry_result_t;

	class pair_list_scoreboard;
		coord_pair_t   pairs[$];
		entry_result_t expected_q[$];
		int depth;
		int errors;
		int n_results;
		int n_append, n_remove, n_list;
		int n_full, n_empty, n_range;

		function new(int depth_i);
			depth = depth_i;
		endfunction

		function int stored();
			return pairs.size();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function entry_result_t make_result(logic [1:0] status, logic [31:0] lat,
				logic [31:0] lon, int pos, bit is_last);
			entry_result_t r;
			r.status  = status;
			r.lat     = lat;
			r.lon     = lon;
			r.pos     = pos[4:0];
			r.cnt     = 5'(pairs.size());
			r.is_last = is_last;
			return r;
		endfunction

		// Update the list copy and queue every result this command causes.
		function void note_command(logic [1:0] cmd, logic [31:0] lat, logic [31:0] lon,
				logic [7:0] pos);
			coord_pair_t p;
			case (cmd)
				CMD_APPEND: begin
					n_append++;
					if (pairs.size() >= depth) begin
						n_full++;
						expected_q.push_back(make_result(ST_FULL, '0, '0, 0, 1'b1));
					end else begin
						p.lat = lat;
						p.lon = lon;
						pairs.push_back(p);
						expected_q.push_back(make_result(ST_OK, lat, lon, pairs.size(), 1'b1));
					end
				end
				CMD_REMOVE: begin
					n_remove++;
					if (pairs.size() == 0) begin
						n_empty++;
						expected_q.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
					end else if (pos < 1 || pos > pairs.size()) begin
						n_range++;
						expected_q.push_back(make_result(ST_RANGE, '0, '0, 0, 1'b1));
					end else begin
						p = pairs[pos - 1];
						pairs.delete(pos - 1);
						expected_q.push_back(make_result(ST_OK, p.lat, p.lon, pos, 1'b1));
					end
				end
				CMD_LIST: begin
					n_list++;
					if (pairs.size() == 0) begin
						n_empty++;
						expected_q.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
					end else begin
						for (int i = 0; i < pairs.size(); i++)
							expected_q.push_back(make_result(ST_OK, pairs[i].lat, pairs[i].lon,
								i + 1, i == pairs.size() - 1));
					end
				end
				default: begin
					// unused command: no result, no state change
				end
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] exp, int idx);
			if (got !== exp)
				report($sformatf("result %0d %s got 0x%0h expected 0x%0h", idx, name, got, exp));
		endtask

		task check_result(entry_result_t got);
			entry_result_t exp;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", n_results));
			end else begin
				exp = expected_q.pop_front();
				check_field("status", 32'(got.status), 32'(exp.status), n_results);
				check_field("entry_latitude", got.lat, exp.lat, n_results);
				check_field("entry_longitude", got.lon, exp.lon, n_results);
				check_field("entry_position", 32'(got.pos), 32'(exp.pos), n_results);
				check_field("entry_count", 32'(got.cnt), 32'(exp.cnt), n_results);
				check_field("last", 32'(got.is_last), 32'(exp.is_last), n_results);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // latitude[31:0], longitude[63:32], position[71:64]
	logic [1:0]  s_tuser;  // command
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;  // entry_latitude[31:0], entry_longitude[63:32],
	                       // entry_position[68:64], entry_count[73:69], zero
	logic [1:0]  m_tuser;  // status
	logic        m_tlast;

	pair_list_scoreboard sb;
	bit quiet;
	int stall_left;

	compacting_pair_list #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// Receiver: stall in random bursts unless the run is in its quiet tail.
	always @(posedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 14);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		entry_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = m_tuser;
			got.lat     = m_tdata[31:0];
			got.lon     = m_tdata[63:32];
			got.pos     = m_tdata[68:64];
			got.cnt     = m_tdata[73:69];
			got.is_last = m_tlast;
			sb.check_result(got);
		end
	end

	task send_command(logic [1:0] cmd, logic [31:0] lat, logic [31:0] lon, logic [7:0] pos);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {pos, lon, lat};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, lat, lon, pos);
	endtask

	task send_random_item(bit grow);
		int roll;
		logic [1:0] cmd;
		logic [7:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			cmd = CMD_UNUSED;
		else if (roll < 20)
			cmd = CMD_LIST;
		else if (roll < (grow ? 80 : 40))
			cmd = CMD_APPEND;
		else
			cmd = CMD_REMOVE;
		// Mostly valid positions; the rest is one past the end or spans the whole field.
		if (sb.stored() > 0 && $urandom_range(0, 4) != 0)
			pos = 8'($urandom_range(1, sb.stored()));
		else if ($urandom_range(0, 1) == 0)
			pos = 8'(sb.stored() + 1);
		else
			pos = 8'($urandom_range(0, 255));
		send_command(cmd, $urandom, $urandom, pos);
	endtask

	initial begin
		int n_random;
		bit grow;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_APPEND;
		m_tready   = 1'b0;
		quiet      = 1'b0;
		stall_left = 0;
		sb = new(LIST_DEPTH);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, extremes, fill to full, range rejects, removes at ends.
		send_command(CMD_LIST, '0, '0, 8'd0);
		send_command(CMD_REMOVE, '0, '0, 8'd1);
		send_command(CMD_UNUSED, $urandom, $urandom, 8'($urandom_range(0, 255)));
		send_command(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000, 8'd0);
		send_command(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, 8'hff);
		send_command(CMD_APPEND, 32'hffff_ffff, 32'h0000_0000, 8'd0);
		while (sb.stored() < LIST_DEPTH)
			send_command(CMD_APPEND, $urandom, $urandom, 8'($urandom_range(0, 255)));
		send_command(CMD_APPEND, $urandom, $urandom, 8'd0);
		send_command(CMD_LIST, '0, '0, 8'd0);
		send_command(CMD_REMOVE, '0, '0, 8'd0);
		send_command(CMD_REMOVE, '0, '0, 8'(LIST_DEPTH + 1));
		send_command(CMD_REMOVE, '0, '0, 8'hff);
		send_command(CMD_REMOVE, '0, '0, 8'(LIST_DEPTH));
		send_command(CMD_REMOVE, '0, '0, 8'd1);
		send_command(CMD_REMOVE, '0, '0, 8'd7);
		send_command(CMD_LIST, '0, '0, 8'd0);

		// Random: mix growing and draining stretches so the list hits both ends.
		n_random = 0;
		grow = 1'b0;
		while (n_random < 70) begin
			if (n_random % 15 == 0)
				grow = $urandom_range(0, 1);
			if (n_random >= 55)
				quiet = 1'b1;
			if (sb.stored() >= LIST_DEPTH)
				grow = 1'b0;
			else if (sb.stored() == 0)
				grow = 1'b1;
			send_random_item(grow);
			if (s_tuser != CMD_UNUSED)
				n_random++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d commands: %0d appends, %0d removes, %0d lists; %0d results",
			sb.n_append + sb.n_remove + sb.n_list, sb.n_append, sb.n_remove, sb.n_list,
			sb.n_results);
		$display("rejections seen: %0d full, %0d empty, %0d out of range",
			sb.n_full, sb.n_empty, sb.n_range);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("compacting_pair_list regression: pass");
		end else begin
			$display("compacting_pair_list regression: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results pending", sb.pending());
		$display("compacting_pair_list regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cpl_pkg.sv
rtl/core/cpl_ctrl.sv
rtl/core/cpl_dpath.sv
rtl/core/compacting_pair_list.sv
tb/sv/compacting_pair_list_tb.sv
